// ===== sv/frpm_pkg.sv =====
package frpm_pkg;

    // Depth of the run store, one chain cell per entry (2..63)
    localparam int RUN_STORE_DEPTH = 32;
    // Burst limit on held pixels
    localparam int BURST_CAP = 32;
    localparam int HOLD_MAX = (RUN_STORE_DEPTH < BURST_CAP) ? RUN_STORE_DEPTH : BURST_CAP;
    localparam int IDX_W = (RUN_STORE_DEPTH > 1) ? $clog2(RUN_STORE_DEPTH) : 1;

    localparam int PX_W = 24;
    localparam int RUN_W = 6;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_COLOR = 2'd2;

    // Register reset values
    localparam logic [7:0] DIFF_LIMIT_RST = 8'd5;
    localparam logic [RUN_W-1:0] MAX_RUN_RST = 6'd21;
    localparam logic [PX_W-1:0] MARK_COLOR_RST = 24'hFF0000;

    localparam logic [RUN_W-1:0] RUN_SAT = 6'd63;
    localparam logic [RUN_W-1:0] HOLD_MAX_V = RUN_W'(HOLD_MAX);

    typedef logic [PX_W-1:0] t_pixel;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    // One channel counts as faint when it rises by 1..limit over the reference
    function automatic logic ch_faint(input logic [7:0] px, input logic [7:0] ref_px,
                                      input logic [7:0] limit);
        logic [7:0] d;
        d = px - ref_px;
        return (px > ref_px) && (d <= limit);
    endfunction

endpackage

// ===== sv/frpm_cell.sv =====
module frpm_cell (
    input  logic                i_clk,
    input  frpm_pkg::t_cell_ctrl i_ctrl,
    input  frpm_pkg::t_pixel    i_px,
    input  frpm_pkg::t_pixel    i_next,
    output frpm_pkg::t_pixel    o_px
);
    import frpm_pkg::*;

    t_pixel r_px;
    t_pixel n_px;

    // Load a new held pixel, or take the neighbor's while draining
    always_comb begin
        n_px = r_px;
        if (i_ctrl.load) begin
            n_px = i_px;
        end else if (i_ctrl.shift) begin
            n_px = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;
    end

    assign o_px = r_px;

endmodule

// ===== sv/faint_run_pixel_marker_unit.sv =====
// Faint run pixel marker.
// Input channel: i_valid / o_stall with one raster pixel (three 8-bit channels),
// frame_start and end_of_pass. A pixel is transferred when i_valid is high and
// o_stall low. Output channel: o_valid / i_stall, one pixel per transfer with
// was_marked and last_of_burst; last_of_burst flags the final result of one input.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) with register index
// 0 diff_limit, 1 max_run, 2 mark_color; other indexes are ignored. Write only
// while the block is idle.
// A faint pixel that is held produces no result unless it carries end_of_pass,
// which flushes the held run unmarked. After an input transfer the burst state
// loads the output register one result per cycle while the output slot is free,
// the run chain shifting one held pixel per result to the output register.
// Input is stalled while a burst is in progress; an output stall freezes the
// burst and the output register holds its pixel.
// Reset (synchronous, active low) restores register defaults, clears the
// reference pixel and run length and empties the output register.
module faint_run_pixel_marker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_ch0,
    input  logic [7:0]  i_pixel_ch1,
    input  logic [7:0]  i_pixel_ch2,
    input  logic        i_frame_start,
    input  logic        i_end_of_pass,
    // Result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_ch0,
    output logic [7:0]  o_out_ch1,
    output logic [7:0]  o_out_ch2,
    output logic        o_was_marked,
    output logic        o_last_of_burst,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [frpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import frpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_BURST = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [7:0]       r_diff_limit;
    logic [RUN_W-1:0] r_max_run;
    t_pixel           r_mark_color;

    t_pixel           r_ref, n_ref;
    logic [RUN_W-1:0] r_run, n_run;
    t_pixel           r_px, n_px;
    logic [RUN_W-1:0] r_drain, n_drain;
    logic             r_drain_mark, n_drain_mark;
    logic             r_emit_px, n_emit_px;

    logic             r_ov, n_ov;
    t_pixel           r_out_px, n_out_px;
    logic             r_out_mark, n_out_mark;
    logic             r_out_last, n_out_last;

    t_pixel           in_px;
    logic             accept;
    logic             faint;
    logic [RUN_W-1:0] cap;
    logic [RUN_W-1:0] run_inc;
    logic             do_store;
    logic             do_shift;
    logic             slot_free;

    t_cell_ctrl       cell_ctrl [RUN_STORE_DEPTH];
    t_pixel           cell_px   [RUN_STORE_DEPTH];
    t_pixel           cell_next [RUN_STORE_DEPTH];

    assign in_px = {i_pixel_ch2, i_pixel_ch1, i_pixel_ch0};
    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slot_free = !r_ov || !i_stall;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_limit <= DIFF_LIMIT_RST;
            r_max_run    <= MAX_RUN_RST;
            r_mark_color <= MARK_COLOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIFF_LIMIT: r_diff_limit <= i_cfg_data[7:0];
                CFG_MAX_RUN:    r_max_run    <= i_cfg_data[RUN_W-1:0];
                CFG_MARK_COLOR: r_mark_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold limit and faint test
    assign cap = (r_max_run > HOLD_MAX_V) ? HOLD_MAX_V : r_max_run;
    assign run_inc = (r_run < RUN_SAT) ? (r_run + RUN_W'(1)) : RUN_SAT;
    assign faint = !i_frame_start
                && ch_faint(i_pixel_ch0, r_ref[7:0],   r_diff_limit)
                && ch_faint(i_pixel_ch1, r_ref[15:8],  r_diff_limit)
                && ch_faint(i_pixel_ch2, r_ref[23:16], r_diff_limit);
    assign do_store = accept && faint && (run_inc <= cap);

    // Sequencer: plan a burst on input, then feed the output register
    always_comb begin
        n_state      = r_state;
        n_ref        = r_ref;
        n_run        = r_run;
        n_px         = r_px;
        n_drain      = r_drain;
        n_drain_mark = r_drain_mark;
        n_emit_px    = r_emit_px;
        n_ov         = r_ov && i_stall;
        n_out_px     = r_out_px;
        n_out_mark   = r_out_mark;
        n_out_last   = r_out_last;
        do_shift     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_px = in_px;
                    if (faint) begin
                        if (run_inc <= cap) begin
                            // held; flush unmarked at end of pass
                            n_drain      = run_inc;
                            n_drain_mark = 1'b0;
                            n_emit_px    = 1'b0;
                            n_run        = i_end_of_pass ? '0 : run_inc;
                            if (i_end_of_pass) begin
                                n_state = S_BURST;
                            end
                        end else begin
                            // run outgrew the hold limit
                            n_drain      = (run_inc == cap + RUN_W'(1)) ? cap : '0;
                            n_drain_mark = 1'b0;
                            n_emit_px    = 1'b1;
                            n_run        = i_end_of_pass ? '0 : run_inc;
                            n_state      = S_BURST;
                        end
                    end else begin
                        // run ends: recolor a short one, then the pixel
                        n_drain      = (r_run != '0 && r_run <= cap) ? r_run : '0;
                        n_drain_mark = 1'b1;
                        n_emit_px    = 1'b1;
                        n_ref        = in_px;
                        n_run        = '0;
                        n_state      = S_BURST;
                    end
                end
            end
            S_BURST: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (r_drain != '0) begin
                        do_shift   = 1'b1;
                        n_drain    = r_drain - RUN_W'(1);
                        n_out_px   = r_drain_mark ? r_mark_color : cell_px[0];
                        n_out_mark = r_drain_mark;
                        n_out_last = (r_drain == RUN_W'(1)) && !r_emit_px;
                        if (n_out_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_out_px   = r_px;
                        n_out_mark = 1'b0;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ref   <= '0;
            r_run   <= '0;
            r_drain <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_run   <= n_run;
            r_drain <= n_drain;
            r_ov    <= n_ov;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_drain_mark <= n_drain_mark;
        r_emit_px    <= n_emit_px;
        r_out_px     <= n_out_px;
        r_out_mark   <= n_out_mark;
        r_out_last   <= n_out_last;
    end

    // Run chain: cell i holds the i-th pixel of the current run
    for (genvar g = 0; g < RUN_STORE_DEPTH; g++) begin : g_cell
        assign cell_ctrl[g].load  = do_store
                                 && ((run_inc - RUN_W'(1)) == RUN_W'(g));
        assign cell_ctrl[g].shift = do_shift;
        if (g == RUN_STORE_DEPTH - 1) begin : g_tail
            assign cell_next[g] = cell_px[g];
        end else begin : g_mid
            assign cell_next[g] = cell_px[g+1];
        end
        frpm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl[g]),
            .i_px   (in_px),
            .i_next (cell_next[g]),
            .o_px   (cell_px[g])
        );
    end

    assign o_valid         = r_ov;
    assign o_out_ch0       = r_out_px[7:0];
    assign o_out_ch1       = r_out_px[15:8];
    assign o_out_ch2       = r_out_px[23:16];
    assign o_was_marked    = r_out_mark;
    assign o_last_of_burst = r_out_last;

endmodule
